[sv/hkic_pkg.sv]
// hex key intake package: types, codes and functions shared by the intake blocks
// no dependencies; used by hkic_front, hkic_back, the top level and the checker
`default_nettype none

package hkic_pkg;

  // key length in bytes and byte counter width
  localparam int unsigned CountWidth = 10;
  localparam logic [CountWidth-1:0] KeyBytes = 10'd800;

  // queue geometry shared by the command and result queues
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // special characters
  localparam logic [7:0] ChEtx   = 8'h03;
  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  // crc-32/iso-hdlc, reflected
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  // result status codes
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_BUSY     = 3'd1,
    ST_OK       = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_ABORT    = 3'd4,
    ST_NONHEX   = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_e;

  // character class decided by the front end
  typedef enum logic [2:0] {
    K_ARM,
    K_ABORT,
    K_SKIP,
    K_NONHEX,
    K_HEX
  } kind_e;

  // classified command passed from front to back
  typedef struct packed {
    kind_e      kind;
    logic [3:0] nib;
  } cmd_t;

  // handshake between front command queue and back end
  typedef struct packed {
    logic avail;
    cmd_t cmd;
  } cmd_port_t;

  // one result transaction
  typedef struct packed {
    logic                  byte_valid;
    logic [7:0]            key_byte;
    logic [CountWidth-1:0] byte_index;
    status_e               status;
    logic [31:0]           computed_crc;
  } res_t;

  // hex digit decode: bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b0, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      r = {1'b0, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      r = {1'b0, d[3:0]};
    end
    return r;
  endfunction

  // fold one byte into the running crc, lsb first
  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/hkic_front.sv]
// hex key intake front end: classifies characters and queues commands
// depends on hkic_pkg
`default_nettype none

module hkic_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic             mode_i,
  input  wire logic [7:0]       char_in_i,
  output hkic_pkg::cmd_port_t   cmd_o,
  input  wire logic             cmd_pop_i
);

  hkic_pkg::cmd_t                      cls;
  logic [4:0]                          hex;
  hkic_pkg::cmd_t                      mem_q [hkic_pkg::QueueDepth];
  logic [hkic_pkg::QueuePtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [hkic_pkg::QueuePtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [hkic_pkg::QueueCntW-1:0]      cnt_q, cnt_d;
  logic                                wr_en, rd_en;

  // character classification
  always_comb begin
    hex      = hkic_pkg::hex_digit(char_in_i);
    cls.nib  = hex[3:0];
    if (!mode_i) begin
      cls.kind = hkic_pkg::K_ARM;
    end else if (char_in_i == hkic_pkg::ChEtx || char_in_i == hkic_pkg::ChEsc) begin
      cls.kind = hkic_pkg::K_ABORT;
    end else if (char_in_i == hkic_pkg::ChSpace || char_in_i == hkic_pkg::ChTab ||
                 char_in_i == hkic_pkg::ChCr || char_in_i == hkic_pkg::ChLf) begin
      cls.kind = hkic_pkg::K_SKIP;
    end else if (hex[4]) begin
      cls.kind = hkic_pkg::K_NONHEX;
    end else begin
      cls.kind = hkic_pkg::K_HEX;
    end
  end

  // queue control
  assign full   = (cnt_q == hkic_pkg::QueueCntW'(hkic_pkg::QueueDepth));
  assign wr_en  = push && !full;
  assign rd_en  = cmd_pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == hkic_pkg::QueuePtrW'(hkic_pkg::QueueDepth - 1)) ? '0
                                                                             : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == hkic_pkg::QueuePtrW'(hkic_pkg::QueueDepth - 1)) ? '0
                                                                             : rd_ptr_q + 1'b1;
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  // head of queue to the back end
  assign cmd_o.avail = (cnt_q != '0);
  assign cmd_o.cmd   = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

[sv/hkic_back.sv]
// hex key intake back end: intake state, byte assembly, crc check, result queue
// depends on hkic_pkg
`default_nettype none

module hkic_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                expected_crc_we_i,
  input  wire logic [31:0]         expected_crc_i,
  input  hkic_pkg::cmd_port_t      cmd_i,
  output logic                     cmd_pop_o,
  output logic                     empty,
  input  wire logic                pop,
  output hkic_pkg::res_t           res_o
);

  logic                                 armed_q, armed_d;
  logic                                 have_high_q, have_high_d;
  logic [3:0]                           high_nib_q, high_nib_d;
  logic [hkic_pkg::CountWidth-1:0]      count_q, count_d, count_inc;
  logic [31:0]                          crc_q, crc_d, crc_new, fcrc;
  logic [31:0]                          expected_q;
  logic [7:0]                           kbyte;
  hkic_pkg::res_t                       res;
  hkic_pkg::res_t                       mem_q [hkic_pkg::QueueDepth];
  logic [hkic_pkg::QueuePtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [hkic_pkg::QueuePtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [hkic_pkg::QueueCntW-1:0]       cnt_q, cnt_d;
  logic                                 res_full, rd_en;

  // expected crc register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= '0;
    end else if (expected_crc_we_i) begin
      expected_q <= expected_crc_i;
    end
  end

  // take a command when the result queue has room
  assign res_full  = (cnt_q == hkic_pkg::QueueCntW'(hkic_pkg::QueueDepth));
  assign cmd_pop_o = cmd_i.avail && !res_full;

  // byte assembly and crc datapath
  assign kbyte     = {high_nib_q, cmd_i.cmd.nib};
  assign crc_new   = hkic_pkg::crc_fold(crc_q, kbyte);
  assign count_inc = count_q + 1'b1;
  assign fcrc      = ~crc_new;

  // intake state update and result forming
  always_comb begin
    armed_d          = armed_q;
    have_high_d      = have_high_q;
    high_nib_d       = high_nib_q;
    count_d          = count_q;
    crc_d            = crc_q;
    res.byte_valid   = 1'b0;
    res.key_byte     = '0;
    res.byte_index   = '0;
    res.status       = hkic_pkg::ST_IDLE;
    res.computed_crc = '0;
    if (cmd_pop_o) begin
      if (cmd_i.cmd.kind == hkic_pkg::K_ARM) begin
        armed_d     = 1'b1;
        have_high_d = 1'b0;
        high_nib_d  = '0;
        count_d     = '0;
        crc_d       = hkic_pkg::CrcInit;
        res.status  = hkic_pkg::ST_BUSY;
      end else if (armed_q) begin
        unique case (cmd_i.cmd.kind)
          hkic_pkg::K_SKIP: begin
            res.status = hkic_pkg::ST_BUSY;
          end
          hkic_pkg::K_ABORT, hkic_pkg::K_NONHEX: begin
            armed_d     = 1'b0;
            have_high_d = 1'b0;
            high_nib_d  = '0;
            count_d     = '0;
            crc_d       = hkic_pkg::CrcInit;
            res.status  = (cmd_i.cmd.kind == hkic_pkg::K_ABORT) ? hkic_pkg::ST_ABORT
                                                                : hkic_pkg::ST_NONHEX;
          end
          hkic_pkg::K_HEX: begin
            if (!have_high_q) begin
              // first nibble of a pair
              have_high_d = 1'b1;
              high_nib_d  = cmd_i.cmd.nib;
              res.status  = hkic_pkg::ST_BUSY;
            end else if (count_q >= hkic_pkg::KeyBytes) begin
              armed_d     = 1'b0;
              have_high_d = 1'b0;
              high_nib_d  = '0;
              count_d     = '0;
              crc_d       = hkic_pkg::CrcInit;
              res.status  = hkic_pkg::ST_OVERFLOW;
            end else begin
              // completed byte
              res.byte_valid = 1'b1;
              res.key_byte   = kbyte;
              res.byte_index = count_q;
              res.status     = hkic_pkg::ST_BUSY;
              have_high_d    = 1'b0;
              high_nib_d     = '0;
              count_d        = count_inc;
              crc_d          = crc_new;
              if (count_inc == hkic_pkg::KeyBytes) begin
                // last byte of the key: check and disarm
                res.computed_crc = fcrc;
                res.status       = (fcrc == expected_q) ? hkic_pkg::ST_OK
                                                        : hkic_pkg::ST_MISMATCH;
                armed_d          = 1'b0;
                count_d          = '0;
                crc_d            = hkic_pkg::CrcInit;
              end
            end
          end
          default: begin
            res.status = hkic_pkg::ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      have_high_q <= 1'b0;
      high_nib_q  <= '0;
      count_q     <= '0;
      crc_q       <= hkic_pkg::CrcInit;
    end else begin
      armed_q     <= armed_d;
      have_high_q <= have_high_d;
      high_nib_q  <= high_nib_d;
      count_q     <= count_d;
      crc_q       <= crc_d;
    end
  end

  // result queue control
  assign rd_en = pop && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (cmd_pop_o) begin
      wr_ptr_d = (wr_ptr_q == hkic_pkg::QueuePtrW'(hkic_pkg::QueueDepth - 1)) ? '0
                                                                             : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == hkic_pkg::QueuePtrW'(hkic_pkg::QueueDepth - 1)) ? '0
                                                                             : rd_ptr_q + 1'b1;
    end
    case ({cmd_pop_o, rd_en})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      mem_q[wr_ptr_q] <= res;
    end
  end

  assign empty = (cnt_q == '0);
  assign res_o = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

[sv/hex_key_intake_crc_check.sv]
// Hex key intake with CRC-32/ISO-HDLC check. Each accepted character (or arm
// command) yields exactly one result transaction. The block takes one
// transaction per cycle while full is low. The front command queue registers
// each command; the back end takes it when the result queue has room and
// writes its result into the result queue, from which it is shown on the
// result ports until popped. Both sides are two-entry queues: full rises only
// when two commands wait because results are not being popped. The crc of a
// key byte is folded by combinational logic in the back end and registered.
// expected_crc is written through expected_crc_we_i / expected_crc_i; the user
// must do so only while the block is idle; the block does not enforce this.
// depends on hkic_pkg, hkic_front, hkic_back
`default_nettype none

module hex_key_intake_crc_check (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        mode_i,
  input  wire logic [7:0]  char_in_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             byte_valid_o,
  output logic [7:0]       key_byte_o,
  output logic [9:0]       byte_index_o,
  output logic [2:0]       status_o,
  output logic [31:0]      computed_crc_o,
  input  wire logic        expected_crc_we_i,
  input  wire logic [31:0] expected_crc_i
);

  hkic_pkg::cmd_port_t cmd;
  logic                cmd_pop;
  hkic_pkg::res_t      res;

  // classifying front end with command queue
  hkic_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .mode_i    (mode_i),
    .char_in_i (char_in_i),
    .cmd_o     (cmd),
    .cmd_pop_i (cmd_pop)
  );

  // executing back end with result queue
  hkic_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .expected_crc_we_i (expected_crc_we_i),
    .expected_crc_i    (expected_crc_i),
    .cmd_i             (cmd),
    .cmd_pop_o         (cmd_pop),
    .empty             (empty),
    .pop               (pop),
    .res_o             (res)
  );

  // result fields
  assign byte_valid_o   = res.byte_valid;
  assign key_byte_o     = res.key_byte;
  assign byte_index_o   = res.byte_index;
  assign status_o       = res.status;
  assign computed_crc_o = res.computed_crc;

endmodule

`default_nettype wire

[sv/hkic_checker.sv]
// port-level checker for the hex key intake, bound to the top level
// depends on hkic_pkg and hex_key_intake_crc_check
`default_nettype none

module hkic_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        byte_valid_o,
  input wire logic [7:0]  key_byte_o,
  input wire logic [9:0]  byte_index_o,
  input wire logic [2:0]  status_o,
  input wire logic [31:0] computed_crc_o
);

  // a decoded byte only comes with in-progress or a final verdict
  a_byte_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && byte_valid_o) |->
      (status_o == hkic_pkg::ST_BUSY || status_o == hkic_pkg::ST_OK ||
       status_o == hkic_pkg::ST_MISMATCH))
    else $error("byte presented with unexpected status");

  // a verdict comes with the last byte of the key
  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == hkic_pkg::ST_OK || status_o == hkic_pkg::ST_MISMATCH)) |->
      (byte_valid_o && byte_index_o == (hkic_pkg::KeyBytes - 10'd1)))
    else $error("verdict without last key byte");

  // crc is zero unless a verdict is shown
  a_crc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != hkic_pkg::ST_OK && status_o != hkic_pkg::ST_MISMATCH) |->
      (computed_crc_o == 32'h0))
    else $error("crc shown without verdict");

  // no byte means zero byte and index
  a_no_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !byte_valid_o) |-> (key_byte_o == 8'h0 && byte_index_o == 10'h0))
    else $error("byte fields set without a byte");

  // a waiting result stays until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(key_byte_o)))
    else $error("waiting result changed");

endmodule

bind hex_key_intake_crc_check hkic_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .byte_valid_o   (byte_valid_o),
  .key_byte_o     (key_byte_o),
  .byte_index_o   (byte_index_o),
  .status_o       (status_o),
  .computed_crc_o (computed_crc_o)
);

`default_nettype wire
